// ===== rtl/core/textured_wall_column_generator_defines.svh =====
// Assertion macros shared by the textured wall column generator modules.
`ifndef TEXTURED_WALL_COLUMN_GENERATOR_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define TWC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TWC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twc: next-cycle check failed");

`else

`define TWC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TWC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/twc_pkg.sv =====
// Shared types, field widths and codes of the textured wall column generator.
package twc_pkg;

   localparam int SCREEN_ROWS_DEFAULT     = 512;
   localparam int TEXTURE_ROWS_DEFAULT    = 64;
   localparam int TEXTURE_COLUMNS_DEFAULT = 64;

   localparam int COLUMN_W    = 12;
   localparam int DIST_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int TEX_ID_W    = 2;
   localparam int PIXEL_ROW_W = 9;
   localparam int KIND_W      = 2;
   localparam int COLOR_W     = 24;
   localparam int TEXEL_W     = 6;
   localparam int HEIGHT_W    = 16;
   localparam int FIX_W       = 32;

   localparam logic [KIND_W-1:0] KIND_CEILING = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WALL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLOOR   = 2'd2;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CEILING_COLOR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR_COLOR   = 4'd1;

   // Queue between front and back; depth is a power of two so pointers wrap.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef struct packed {
      logic                is_row;
      logic [COLUMN_W-1:0] column;
      logic [DIST_W-1:0]   wall_distance;
      logic [FRAC_W-1:0]   hit_fraction;
      logic                mirror;
      logic [TEX_ID_W-1:0] texture_select;
   } queue_item_type;

endpackage

// ===== rtl/core/twc_front.sv =====
// Front end: takes request transactions, classifies them and queues them.
`include "textured_wall_column_generator_defines.svh"

module twc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [twc_pkg::COLUMN_W-1:0]        req_column,
   input  logic [twc_pkg::DIST_W-1:0]          req_wall_distance,
   input  logic [twc_pkg::FRAC_W-1:0]          req_hit_fraction,
   input  logic                                req_wall_side,
   input  logic                                req_dir_x_positive,
   input  logic                                req_dir_y_negative,
   input  logic [twc_pkg::TEX_ID_W-1:0]        req_texture_select,
   output logic                                q_valid,
   output twc_pkg::queue_item_type             q_item,
   input  logic                                q_pop
);

   localparam int QD   = twc_pkg::QUEUE_DEPTH;
   localparam int QP_W = twc_pkg::QPTR_W;
   localparam int QC_W = $clog2(QD + 1);

   twc_pkg::queue_item_type item_ff [QD];
   twc_pkg::queue_item_type item_in;
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] count_ff, count_in;
   logic            push;
   logic            pop;

   assign req_ready = (count_ff != QC_W'(QD));
   assign q_valid   = (count_ff != '0);
   assign q_item    = item_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      item_in.is_row         = req_action;
      item_in.column         = req_column;
      item_in.wall_distance  = req_wall_distance;
      item_in.hit_fraction   = req_hit_fraction;
      // mirror the texture column on faces seen from the far side
      item_in.mirror         = (!req_wall_side && req_dir_x_positive) ||
                               (req_wall_side && req_dir_y_negative);
      item_in.texture_select = req_texture_select;

      wr_ptr_in = push ? wr_ptr_ff + QP_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QP_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= item_in;
      end
   end

   `TWC_ASSERT_IMP(a_queue_bounded, clock, reset, 1'b1, count_ff <= QC_W'(QD))

endmodule

// ===== rtl/core/twc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module twc_div #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic                  fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      // remainder stays below the divisor, so its top bit is always clear here
      trial   = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? trial - {1'b0, dsr_ff} : trial;
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== rtl/core/twc_back.sv =====
// Back end: column set-up sequencer and per-row pixel generation.
`include "textured_wall_column_generator_defines.svh"

module twc_back #(
   parameter int SCREEN_ROWS     = twc_pkg::SCREEN_ROWS_DEFAULT,
   parameter int TEXTURE_ROWS    = twc_pkg::TEXTURE_ROWS_DEFAULT,
   parameter int TEXTURE_COLUMNS = twc_pkg::TEXTURE_COLUMNS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  twc_pkg::queue_item_type            q_item,
   output logic                               q_pop,
   input  logic [twc_pkg::COLOR_W-1:0]        ceiling_color,
   input  logic [twc_pkg::COLOR_W-1:0]        floor_color,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [twc_pkg::COLUMN_W-1:0]       rsp_pixel_column,
   output logic [twc_pkg::PIXEL_ROW_W-1:0]    rsp_pixel_row,
   output logic [twc_pkg::KIND_W-1:0]         rsp_pixel_kind,
   output logic [twc_pkg::COLOR_W-1:0]        rsp_flat_color,
   output logic [twc_pkg::TEX_ID_W-1:0]       rsp_texture_id,
   output logic [twc_pkg::TEXEL_W-1:0]        rsp_texel_column,
   output logic [twc_pkg::TEXEL_W-1:0]        rsp_texel_row,
   output logic                               rsp_last_row
);

   localparam int ROW_W  = $clog2(SCREEN_ROWS);
   localparam int MID    = SCREEN_ROWS / 2;
   localparam int SRW    = $clog2(SCREEN_ROWS + 1);
   localparam int TRW    = $clog2(TEXTURE_ROWS + 1);
   localparam int DIV_A  = SRW + 16;
   localparam int DIV_B  = TRW + 24;
   localparam int DIV_AB = (DIV_A > DIV_B) ? DIV_A : DIV_B;
   localparam int DIV_W  = (DIV_AB > 32) ? DIV_AB : 33;
   localparam int TCW    = $clog2(TEXTURE_COLUMNS + 1);
   localparam int TCP_W  = twc_pkg::FRAC_W + TCW;
   localparam int HW     = twc_pkg::HEIGHT_W + 1;
   localparam int H_W    = twc_pkg::HEIGHT_W;
   localparam int F_W    = twc_pkg::FIX_W;
   localparam int PR_W   = twc_pkg::PIXEL_ROW_W;
   localparam int TX_W   = twc_pkg::TEXEL_W;
   localparam int C_W    = twc_pkg::COLOR_W;
   localparam int MUL_W  = H_W + F_W;
   localparam logic [7:0] TROW_MASK = 8'(TEXTURE_ROWS - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_DIV_H = 4'b0010,
      S_DIV_S = 4'b0100,
      S_MUL   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      active_ff, active_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [twc_pkg::COLUMN_W-1:0] column_ff, column_in;
   logic [twc_pkg::TEX_ID_W-1:0] tid_ff, tid_in;
   logic [TX_W-1:0]              tcol_ff, tcol_in;
   logic                         dist_zero_ff, dist_zero_in;
   logic [H_W-1:0]               height_ff, height_in;
   logic [ROW_W-1:0]             first_ff, first_in;
   logic [ROW_W-1:0]             last_ff, last_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [H_W-1:0]               offset_ff, offset_in;
   logic [F_W-1:0]               step_ff, step_in;
   logic [F_W-1:0]               pos_ff, pos_in;

   logic [twc_pkg::COLUMN_W-1:0] rsp_column_ff, rsp_column_in;
   logic [PR_W-1:0]              rsp_row_ff, rsp_row_in;
   logic [twc_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [C_W-1:0]               rsp_color_ff, rsp_color_in;
   logic [twc_pkg::TEX_ID_W-1:0] rsp_tid_ff, rsp_tid_in;
   logic [TX_W-1:0]              rsp_tcol_ff, rsp_tcol_in;
   logic [TX_W-1:0]              rsp_trow_ff, rsp_trow_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [F_W-1:0]   div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;

   logic             in_idle;
   logic             slot_free;
   logic             emit;
   logic             on_wall;
   logic             at_bottom;
   logic [TCP_W-1:0] tc_prod;
   logic [TCW-1:0]   tc_raw;
   logic [TCW-1:0]   tc_sel;
   logic [HW-1:0]    half17;
   logic [HW-1:0]    mid17;
   logic [HW-1:0]    first17;
   logic [HW-1:0]    sum17;
   logic [HW-1:0]    last17;
   logic [HW-1:0]    offset17;
   logic [MUL_W-1:0] mul_prod;

   twc_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (F_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign in_idle   = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = in_idle && q_valid && q_item.is_row && active_ff && slot_free;
   // rows with no active column are dropped; loads always leave the queue
   assign q_pop     = in_idle && q_valid && (!q_item.is_row || !active_ff || slot_free);
   assign on_wall   = (row_ff >= first_ff) && (row_ff <= last_ff);
   assign at_bottom = (row_ff == ROW_W'(SCREEN_ROWS - 1));

   always_comb begin
      tc_prod  = TCP_W'(q_item.hit_fraction) * TCP_W'(TEXTURE_COLUMNS);
      tc_raw   = tc_prod[TCP_W-1:twc_pkg::FRAC_W];
      tc_sel   = q_item.mirror ? TCW'(TEXTURE_COLUMNS - 1) - tc_raw : tc_raw;

      half17   = HW'(height_ff[H_W-1:1]);
      mid17    = HW'(MID);
      first17  = (mid17 > half17) ? mid17 - half17 : '0;
      sum17    = half17 + mid17;
      last17   = (sum17 > HW'(SCREEN_ROWS - 1)) ? HW'(SCREEN_ROWS - 1) : sum17;
      offset17 = first17 + half17 - mid17;

      mul_prod = MUL_W'(offset_ff) * MUL_W'(step_ff);
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      column_in    = column_ff;
      tid_in       = tid_ff;
      tcol_in      = tcol_ff;
      dist_zero_in = dist_zero_ff;
      height_in    = height_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      row_in       = row_ff;
      offset_in    = offset_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && !q_item.is_row) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(SCREEN_ROWS) << 16;
               div_divisor  = q_item.wall_distance;
               column_in    = q_item.column;
               tid_in       = q_item.texture_select;
               tcol_in      = TX_W'(tc_sel);
               dist_zero_in = (q_item.wall_distance == '0);
               state_in     = S_DIV_H;
            end
         end
         S_DIV_H: begin
            if (div_done) begin
               if (dist_zero_ff || (|div_quotient[DIV_W-1:H_W])) begin
                  height_in = '1;
               end else begin
                  height_in = div_quotient[H_W-1:0];
               end
               div_start    = 1'b1;
               div_dividend = DIV_W'(TEXTURE_ROWS) << 24;
               div_divisor  = F_W'(height_in);
               state_in     = S_DIV_S;
            end
         end
         S_DIV_S: begin
            if (div_done) begin
               if ((height_ff == '0) || (|div_quotient[DIV_W-1:F_W])) begin
                  step_in = '1;
               end else begin
                  step_in = div_quotient[F_W-1:0];
               end
               first_in  = ROW_W'(first17);
               last_in   = ROW_W'(last17);
               offset_in = offset17[H_W-1:0];
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            pos_in    = mul_prod[F_W-1:0];
            row_in    = '0;
            active_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         if (on_wall) begin
            pos_in = pos_ff + step_ff;
         end
         if (at_bottom) begin
            active_in = 1'b0;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = emit || (rsp_valid_ff && !rsp_ready);
      rsp_column_in = column_ff;
      rsp_row_in    = PR_W'(row_ff);
      rsp_last_in   = at_bottom;
      rsp_kind_in   = twc_pkg::KIND_WALL;
      rsp_color_in  = '0;
      rsp_tid_in    = '0;
      rsp_tcol_in   = '0;
      rsp_trow_in   = '0;
      if (on_wall) begin
         rsp_tid_in  = tid_ff;
         rsp_tcol_in = tcol_ff;
         rsp_trow_in = TX_W'(pos_ff[F_W-1:24] & TROW_MASK);
      end else if (row_ff < ROW_W'(MID)) begin
         rsp_kind_in  = twc_pkg::KIND_CEILING;
         rsp_color_in = ceiling_color;
      end else begin
         rsp_kind_in  = twc_pkg::KIND_FLOOR;
         rsp_color_in = floor_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff    <= column_in;
      tid_ff       <= tid_in;
      tcol_ff      <= tcol_in;
      dist_zero_ff <= dist_zero_in;
      height_ff    <= height_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      row_ff       <= row_in;
      offset_ff    <= offset_in;
      step_ff      <= step_in;
      pos_ff       <= pos_in;
      // hold the pixel while the consumer stalls
      if (emit) begin
         rsp_column_ff <= rsp_column_in;
         rsp_row_ff    <= rsp_row_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_color_ff  <= rsp_color_in;
         rsp_tid_ff    <= rsp_tid_in;
         rsp_tcol_ff   <= rsp_tcol_in;
         rsp_trow_ff   <= rsp_trow_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_column = rsp_column_ff;
   assign rsp_pixel_row    = rsp_row_ff;
   assign rsp_pixel_kind   = rsp_kind_ff;
   assign rsp_flat_color   = rsp_color_ff;
   assign rsp_texture_id   = rsp_tid_ff;
   assign rsp_texel_column = rsp_tcol_ff;
   assign rsp_texel_row    = rsp_trow_ff;
   assign rsp_last_row     = rsp_last_ff;

   `TWC_ASSERT_IMP(a_div_done_in_setup, clock, reset, div_done, (state_ff == S_DIV_H) || (state_ff == S_DIV_S))
   `TWC_ASSERT_NXT(a_setup_starts_top, clock, reset, state_ff == S_MUL, active_ff && (row_ff == '0))
   `TWC_ASSERT_IMP(a_span_straddles_mid, clock, reset, active_ff, (first_ff <= ROW_W'(MID)) && (last_ff >= ROW_W'(MID)))
   `TWC_ASSERT_NXT(a_bottom_ends_column, clock, reset, emit && at_bottom, !active_ff)

endmodule

// ===== rtl/core/textured_wall_column_generator.sv =====
// Top level of the textured wall column generator: control registers, front and back.
//
// Channel  Dir  Handshake              Carries
// req      in   req_valid/req_ready    column load or next-row request
// rsp      out  rsp_valid/rsp_ready    one pixel per transaction
// csr      in   csr_valid/csr_ready    register index and 24-bit data
//
// Rows stream at one per clock unless a load is in set-up or rsp_ready stalls the output.
// A load steps through S_DIV_H, S_DIV_S and S_MUL, using the shared restoring
// divider that produces one quotient bit per cycle for the wall height, then the step.
// Reset is synchronous; it clears the colours, the queue, the sequencer and the active flag.
// With rsp_ready low the output register holds its pixel; the two-entry queue keeps
// taking transactions until it is full. csr writes are taken every cycle.
module textured_wall_column_generator #(
   parameter int SCREEN_ROWS     = twc_pkg::SCREEN_ROWS_DEFAULT,
   parameter int TEXTURE_ROWS    = twc_pkg::TEXTURE_ROWS_DEFAULT,
   parameter int TEXTURE_COLUMNS = twc_pkg::TEXTURE_COLUMNS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [twc_pkg::COLUMN_W-1:0]       req_column,
   input  logic [twc_pkg::DIST_W-1:0]         req_wall_distance,
   input  logic [twc_pkg::FRAC_W-1:0]         req_hit_fraction,
   input  logic                               req_wall_side,
   input  logic                               req_dir_x_positive,
   input  logic                               req_dir_y_negative,
   input  logic [twc_pkg::TEX_ID_W-1:0]       req_texture_select,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [twc_pkg::COLUMN_W-1:0]       rsp_pixel_column,
   output logic [twc_pkg::PIXEL_ROW_W-1:0]    rsp_pixel_row,
   output logic [twc_pkg::KIND_W-1:0]         rsp_pixel_kind,
   output logic [twc_pkg::COLOR_W-1:0]        rsp_flat_color,
   output logic [twc_pkg::TEX_ID_W-1:0]       rsp_texture_id,
   output logic [twc_pkg::TEXEL_W-1:0]        rsp_texel_column,
   output logic [twc_pkg::TEXEL_W-1:0]        rsp_texel_row,
   output logic                               rsp_last_row,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [twc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [twc_pkg::COLOR_W-1:0]        csr_data
);

   logic [twc_pkg::COLOR_W-1:0] ceiling_ff, ceiling_in;
   logic [twc_pkg::COLOR_W-1:0] floor_ff, floor_in;
   logic                        csr_write;

   logic                        q_valid;
   logic                        q_pop;
   twc_pkg::queue_item_type     q_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      ceiling_in = ceiling_ff;
      floor_in   = floor_ff;
      if (csr_write) begin
         case (csr_index)
            twc_pkg::CSR_CEILING_COLOR: ceiling_in = csr_data;
            twc_pkg::CSR_FLOOR_COLOR:   floor_in   = csr_data;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff   <= '0;
      end else begin
         ceiling_ff <= ceiling_in;
         floor_ff   <= floor_in;
      end
   end

   twc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_column         (req_column),
      .req_wall_distance  (req_wall_distance),
      .req_hit_fraction   (req_hit_fraction),
      .req_wall_side      (req_wall_side),
      .req_dir_x_positive (req_dir_x_positive),
      .req_dir_y_negative (req_dir_y_negative),
      .req_texture_select (req_texture_select),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   twc_back #(
      .SCREEN_ROWS     (SCREEN_ROWS),
      .TEXTURE_ROWS    (TEXTURE_ROWS),
      .TEXTURE_COLUMNS (TEXTURE_COLUMNS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .ceiling_color    (ceiling_ff),
      .floor_color      (floor_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_kind   (rsp_pixel_kind),
      .rsp_flat_color   (rsp_flat_color),
      .rsp_texture_id   (rsp_texture_id),
      .rsp_texel_column (rsp_texel_column),
      .rsp_texel_row    (rsp_texel_row),
      .rsp_last_row     (rsp_last_row)
   );

endmodule
